@@ design/ggs_pkg.sv @@
`default_nettype none
package ggs_pkg;

	typedef enum logic [2:0] {
		MODE_SAMPLE  = 3'd0,
		MODE_CONNECT = 3'd1,
		MODE_INIT    = 3'd2,
		MODE_HOLD    = 3'd3,
		MODE_RELEASE = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		PH_OFF           = 4'd0,
		PH_INITIALIZING  = 4'd1,
		PH_INITIALIZED   = 4'd2,
		PH_START_RELEASE = 4'd3,
		PH_START_HOLD    = 4'd4,
		PH_KEEP_RELEASE  = 4'd5,
		PH_KEEP_HOLD     = 4'd6,
		PH_MISS_RELEASE  = 4'd7,
		PH_MISS_HOLD     = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		REP_NONE          = 3'd0,
		REP_INIT_OK       = 3'd1,
		REP_INIT_FAIL     = 3'd2,
		REP_START_RELEASE = 3'd3,
		REP_START_HOLD    = 3'd4,
		REP_MISS_RELEASE  = 3'd5,
		REP_MISS_HOLD     = 3'd6
	} report_t;

	typedef enum logic [2:0] {
		CFG_INIT_TIMEOUT = 3'd0,
		CFG_RUN_TIMEOUT  = 3'd1,
		CFG_ANGLE_WINDOW = 3'd2,
		CFG_IDLE_CURRENT = 3'd3,
		CFG_HOLD_TRIP    = 3'd4,
		CFG_SLIP_MARGIN  = 3'd5,
		CFG_SURGE_BASE   = 3'd6,
		CFG_SURGE_STEP   = 3'd7
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Angles in degrees; scaled values are degrees * 4096 to match position * 360
	localparam logic [8:0]  ANG_REL        = 9'd330;
	localparam logic [8:0]  ANG_HOLD       = 9'd290;
	localparam logic [8:0]  ANG_HOLD_GOAL  = 9'd280;
	localparam logic [20:0] ANG_REL_X4096  = 21'd1351680;
	localparam logic [20:0] ANG_SURGE_X4096 = 21'd1196032;
	localparam logic [20:0] DEG_TO_COUNTS  = 21'd360;

	localparam logic [15:0] FORCE_LOW     = 16'd10;
	localparam logic [15:0] FORCE_HIGH    = 16'd200;
	localparam logic [7:0]  CUR_LOW       = 8'd30;
	localparam logic [7:0]  CUR_HIGH      = 8'd100;
	localparam logic [7:0]  CUR_MISS_HOLD = 8'd200;
	localparam logic [7:0]  CUR_MISS_REL  = 8'd20;

	typedef struct packed {
		logic [15:0] init_timeout_ms;
		logic [15:0] run_timeout_ms;
		logic [8:0]  angle_window_deg;
		logic [14:0] idle_current_limit;
		logic [14:0] hold_current_trip;
		logic [8:0]  hold_slip_margin_deg;
		logic [14:0] surge_base_current;
		logic [14:0] surge_step_current;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		init_timeout_ms:      16'd1000,
		run_timeout_ms:       16'd500,
		angle_window_deg:     9'd5,
		idle_current_limit:   15'd10,
		hold_current_trip:    15'd45,
		hold_slip_margin_deg: 9'd9,
		surge_base_current:   15'd60,
		surge_step_current:   15'd30
	};

	typedef struct packed {
		phase_t             phase;
		logic               torque_enabled;
		logic               connect_pending;
		logic signed [15:0] prev_current;
		logic [8:0]         target_angle;
		logic [7:0]         target_current;
		logic [31:0]        pos_start;
		logic               pos_run;
		logic [31:0]        cur_start;
		logic               cur_run;
	} state_t;

	localparam state_t ST_RESET = '{
		phase:           PH_OFF,
		torque_enabled:  1'b0,
		connect_pending: 1'b0,
		prev_current:    16'sd0,
		target_angle:    9'd0,
		target_current:  CUR_LOW,
		pos_start:       32'd0,
		pos_run:         1'b0,
		cur_start:       32'd0,
		cur_run:         1'b0
	};

	typedef struct packed {
		logic [2:0]         mode;
		logic [11:0]        position;
		logic signed [15:0] motor_current;
		logic [31:0]        now_ms;
		logic [15:0]        force_code;
	} cmd_t;

	typedef struct packed {
		logic       goal_valid;
		logic [8:0] goal_angle_deg;
		logic [7:0] goal_current;
		logic [2:0] report_code;
		logic       connect_ack;
		logic [3:0] gripper_phase;
		logic       torque_on;
	} res_t;

endpackage
`default_nettype wire

@@ design/ggs_ifs.sv @@
`default_nettype none
interface ggs_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [11:0]        position;
	logic signed [15:0] motor_current;
	logic [31:0]        now_ms;
	logic [15:0]        force_code;

	modport source (output valid, mode, position, motor_current, now_ms, force_code,
		input ready);
	modport sink (input valid, mode, position, motor_current, now_ms, force_code,
		output ready);
endinterface

interface ggs_res_if;
	logic       valid;
	logic       ready;
	logic       goal_valid;
	logic [8:0] goal_angle_deg;
	logic [7:0] goal_current;
	logic [2:0] report_code;
	logic       connect_ack;
	logic [3:0] gripper_phase;
	logic       torque_on;

	modport source (output valid, goal_valid, goal_angle_deg, goal_current, report_code,
		connect_ack, gripper_phase, torque_on, input ready);
	modport sink (input valid, goal_valid, goal_angle_deg, goal_current, report_code,
		connect_ack, gripper_phase, torque_on, output ready);
endinterface
`default_nettype wire

@@ design/gripper_grasp_supervisor.sv @@
// Gripper grasp supervisor.
// cmd channel (valid/ready): one word per command (connect, initialize, hold,
//   release, with a force code) or per periodic sample of position, current
//   and millisecond timestamp; a word is taken when valid and ready are high.
// res channel (valid/ready): exactly one result word per command word, in
//   order, carrying goal angle and current, a report code, the connect
//   acknowledge, the supervisor phase and the torque enable.
// cfg port: write enable, register index and 16-bit data; write only while
//   no word is in flight. Data is masked to the register's width.
// Path: a taken word is registered in the input register, evaluated, and its
//   result registered in the result register, which drives res.valid.
// Throughput: one word per cycle unless res stalls. The whole supervisor step
//   is one short combinational pass between the input register and the result
//   register, and the state registers update on that same edge.
// Stall: when res.ready is low the result register holds; one more word may
//   wait in the input register, after which cmd.ready drops.
// Reset (arst_n low, asynchronous): phase off, torque off, timers stopped,
//   target current 30, configuration registers back to their default values.
`default_nettype none
module gripper_grasp_supervisor (
	input  wire                              clk,
	input  wire                              arst_n,
	ggs_cmd_if.sink                          cmd,
	ggs_res_if.source                        res,
	input  wire                              cfg_we,
	input  wire [ggs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [ggs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	ggs_pkg::cfg_t   cfg_q;
	ggs_pkg::state_t st_q;
	ggs_pkg::state_t st_nxt;
	ggs_pkg::cmd_t   cmd_s1;
	logic            valid_s1;
	ggs_pkg::res_t   res_c;
	ggs_pkg::res_t   res_q;
	logic            res_valid_q;
	logic            advance;

	// Move the staged word into the result register when that register is free
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ggs_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ggs_pkg::CFG_INIT_TIMEOUT: cfg_q.init_timeout_ms      <= cfg_wdata;
				ggs_pkg::CFG_RUN_TIMEOUT:  cfg_q.run_timeout_ms       <= cfg_wdata;
				ggs_pkg::CFG_ANGLE_WINDOW: cfg_q.angle_window_deg     <= cfg_wdata[8:0];
				ggs_pkg::CFG_IDLE_CURRENT: cfg_q.idle_current_limit   <= cfg_wdata[14:0];
				ggs_pkg::CFG_HOLD_TRIP:    cfg_q.hold_current_trip    <= cfg_wdata[14:0];
				ggs_pkg::CFG_SLIP_MARGIN:  cfg_q.hold_slip_margin_deg <= cfg_wdata[8:0];
				ggs_pkg::CFG_SURGE_BASE:   cfg_q.surge_base_current   <= cfg_wdata[14:0];
				ggs_pkg::CFG_SURGE_STEP:   cfg_q.surge_step_current   <= cfg_wdata[14:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: capture a word whenever the stage is free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.mode          <= cmd.mode;
			cmd_s1.position      <= cmd.position;
			cmd_s1.motor_current <= cmd.motor_current;
			cmd_s1.now_ms        <= cmd.now_ms;
			cmd_s1.force_code    <= cmd.force_code;
		end
	end

	// One supervisor step: checks, timers, next phase and goals
	ggs_step u_step (
		.cmd (cmd_s1),
		.st  (st_q),
		.cfg (cfg_q),
		.nxt (st_nxt),
		.res (res_c)
	);

	// Supervisor state advances together with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ggs_pkg::ST_RESET;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Result register: hold while the receiver stalls, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.goal_valid     = res_q.goal_valid;
	assign res.goal_angle_deg = res_q.goal_angle_deg;
	assign res.goal_current   = res_q.goal_current;
	assign res.report_code    = res_q.report_code;
	assign res.connect_ack    = res_q.connect_ack;
	assign res.gripper_phase  = res_q.gripper_phase;
	assign res.torque_on      = res_q.torque_on;

endmodule
`default_nettype wire

@@ design/ggs_step.sv @@
`default_nettype none
module ggs_step (
	input  ggs_pkg::cmd_t   cmd,
	input  ggs_pkg::state_t st,
	input  ggs_pkg::cfg_t   cfg,
	output ggs_pkg::state_t nxt,
	output ggs_pkg::res_t   res
);

	typedef struct packed {
		logic [31:0] start;
		logic        run;
		logic        fire;
	} tmr_t;

	function automatic tmr_t tick(input logic [31:0] start, input logic run,
		input logic expired, input logic [31:0] now);
		tmr_t t;
		t.start = start;
		t.run   = run;
		t.fire  = 1'b0;
		if (!run) begin
			t.start = now;
			t.run   = 1'b1;
		end else if (expired) begin
			t.run  = 1'b0;
			t.fire = 1'b1;
		end
		return t;
	endfunction

	logic [20:0]        pos360;
	logic [20:0]        dev;
	logic               in_win;
	logic [15:0]        acur;
	logic               cur_high;
	logic [15:0]        limit;
	logic               pos_exp;
	logic               cur_exp;
	logic [8:0]         slip_deg;
	logic               slip_miss;
	logic               trip_miss;
	logic signed [16:0] rise;
	logic               surge_miss;

	assign pos360   = 21'(cmd.position) * ggs_pkg::DEG_TO_COUNTS;
	assign dev      = (pos360 >= ggs_pkg::ANG_REL_X4096) ? pos360 - ggs_pkg::ANG_REL_X4096
		: ggs_pkg::ANG_REL_X4096 - pos360;
	assign in_win   = dev < {cfg.angle_window_deg, 12'd0};
	assign acur     = cmd.motor_current[15] ? 16'(-cmd.motor_current) : cmd.motor_current;
	assign cur_high = acur > {1'b0, cfg.idle_current_limit};

	// Initializing phase waits on its own hold-off, everything else on the run one
	assign limit   = (st.phase == ggs_pkg::PH_INITIALIZING) ? cfg.init_timeout_ms
		: cfg.run_timeout_ms;
	assign pos_exp = (cmd.now_ms - st.pos_start) > {16'd0, limit};
	assign cur_exp = (cmd.now_ms - st.cur_start) > {16'd0, limit};

	// Slip threshold would drop below zero when the margin passes the holding angle; the slip check is then off
	assign slip_deg   = ggs_pkg::ANG_HOLD - cfg.hold_slip_margin_deg;
	assign slip_miss  = (cfg.hold_slip_margin_deg <= ggs_pkg::ANG_HOLD)
		&& (pos360 < {slip_deg, 12'd0});
	assign trip_miss  = cmd.motor_current > $signed({1'b0, cfg.hold_current_trip});
	assign rise       = 17'(cmd.motor_current) - 17'(st.prev_current);
	assign surge_miss = (st.prev_current > $signed({1'b0, cfg.surge_base_current}))
		&& (pos360 < ggs_pkg::ANG_SURGE_X4096)
		&& (rise > $signed({2'b00, cfg.surge_step_current}));

	always_comb begin
		tmr_t t;
		logic fail;
		logic ok;
		nxt  = st;
		res  = '0;
		t    = '0;
		fail = 1'b0;
		ok   = 1'b0;
		case (cmd.mode)
			ggs_pkg::MODE_CONNECT: begin
				nxt.connect_pending = 1'b1;
			end
			ggs_pkg::MODE_INIT, ggs_pkg::MODE_HOLD, ggs_pkg::MODE_RELEASE: begin
				if (cmd.mode == ggs_pkg::MODE_INIT) begin
					nxt.torque_enabled = 1'b1;
					nxt.phase          = ggs_pkg::PH_INITIALIZING;
					nxt.target_angle   = ggs_pkg::ANG_REL;
				end else if (cmd.mode == ggs_pkg::MODE_HOLD) begin
					nxt.phase        = ggs_pkg::PH_START_HOLD;
					nxt.target_angle = ggs_pkg::ANG_HOLD_GOAL;
				end else begin
					nxt.phase        = ggs_pkg::PH_START_RELEASE;
					nxt.target_angle = ggs_pkg::ANG_REL;
				end
				if (cmd.force_code == ggs_pkg::FORCE_LOW) begin
					nxt.target_current = ggs_pkg::CUR_LOW;
				end else if (cmd.force_code == ggs_pkg::FORCE_HIGH) begin
					nxt.target_current = ggs_pkg::CUR_HIGH;
				end
				nxt.pos_run = 1'b0;
				nxt.cur_run = 1'b0;
			end
			ggs_pkg::MODE_SAMPLE: begin
				res.connect_ack     = st.connect_pending;
				nxt.connect_pending = 1'b0;
				nxt.prev_current    = cmd.motor_current;
				if (st.torque_enabled) begin
					case (st.phase)
						ggs_pkg::PH_INITIALIZING, ggs_pkg::PH_INITIALIZED,
						ggs_pkg::PH_KEEP_RELEASE: begin
							// Window and overcurrent checks around the release angle
							if (in_win) begin
								if (cur_high) begin
									t = tick(st.cur_start, st.cur_run, cur_exp, cmd.now_ms);
									nxt.cur_start = t.start;
									nxt.cur_run   = t.run;
									fail          = t.fire;
								end else if (st.phase == ggs_pkg::PH_INITIALIZING) begin
									ok = 1'b1;
								end else begin
									nxt.cur_run = 1'b0;
								end
								nxt.pos_run = 1'b0;
							end else begin
								t = tick(st.pos_start, st.pos_run, pos_exp, cmd.now_ms);
								nxt.pos_start = t.start;
								nxt.pos_run   = t.run;
								fail          = t.fire;
							end
							if (st.phase == ggs_pkg::PH_INITIALIZING) begin
								if (ok) begin
									res.report_code = ggs_pkg::REP_INIT_OK;
									nxt.phase       = ggs_pkg::PH_INITIALIZED;
									nxt.pos_run     = 1'b0;
									nxt.cur_run     = 1'b0;
								end else if (fail) begin
									res.report_code = ggs_pkg::REP_INIT_FAIL;
								end
							end else if (st.phase == ggs_pkg::PH_INITIALIZED) begin
								if (fail) begin
									res.report_code = ggs_pkg::REP_INIT_FAIL;
									nxt.phase       = ggs_pkg::PH_INITIALIZING;
									nxt.pos_run     = 1'b0;
									nxt.cur_run     = 1'b0;
								end
							end else if (fail) begin
								res.report_code = ggs_pkg::REP_MISS_RELEASE;
								nxt.phase       = ggs_pkg::PH_MISS_RELEASE;
							end
						end
						ggs_pkg::PH_START_RELEASE: begin
							res.report_code = ggs_pkg::REP_START_RELEASE;
							nxt.phase       = ggs_pkg::PH_KEEP_RELEASE;
						end
						ggs_pkg::PH_START_HOLD: begin
							res.report_code = ggs_pkg::REP_START_HOLD;
							nxt.phase       = ggs_pkg::PH_KEEP_HOLD;
						end
						ggs_pkg::PH_KEEP_HOLD: begin
							if (slip_miss || trip_miss || surge_miss) begin
								nxt.pos_run        = 1'b0;
								nxt.target_angle   = ggs_pkg::ANG_REL;
								nxt.target_current = ggs_pkg::CUR_MISS_HOLD;
								nxt.phase          = ggs_pkg::PH_MISS_HOLD;
								res.report_code    = ggs_pkg::REP_MISS_HOLD;
							end
						end
						ggs_pkg::PH_MISS_HOLD: begin
							nxt.target_current = ggs_pkg::CUR_LOW;
							nxt.target_angle   = ggs_pkg::ANG_REL;
						end
						ggs_pkg::PH_MISS_RELEASE: begin
							nxt.target_current = ggs_pkg::CUR_MISS_REL;
							nxt.target_angle   = ggs_pkg::ANG_REL;
						end
						default: begin
						end
					endcase
					res.goal_valid     = 1'b1;
					res.goal_angle_deg = nxt.target_angle;
					res.goal_current   = nxt.target_current;
				end
			end
			default: begin
			end
		endcase
		res.gripper_phase = 4'(nxt.phase);
		res.torque_on     = nxt.torque_enabled;
	end

endmodule
`default_nettype wire
